// File: design/smpf_pkg.sv
// ----------------------------------------------------------------------------
// smpf_pkg
// Types and constants shared by the spectrum magnitude and peak finder and
// its port checker.
// ----------------------------------------------------------------------------
package smpf_pkg;

    localparam int BINS_DEFAULT = 128;
    localparam int HALF_W       = 16;
    localparam int BIN_W        = 32;
    localparam int IDX_W        = 7;
    localparam int MAG_W        = 17;
    localparam int SUM_W        = 32;
    localparam int RAD_W        = 2 * MAG_W;
    localparam int REM_W        = MAG_W + 1;
    localparam int ROOT_STEPS   = MAG_W;

    typedef struct packed {
        logic [BIN_W-1:0] fft_bin;
        logic             last_bin;
    } in_word_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [IDX_W-1:0] bin_index;
        logic [IDX_W-1:0] peak_index;
        logic [MAG_W-1:0] peak_magnitude;
        logic             frame_done;
    } out_word_t;

endpackage

// File: design/spectrum_magnitude_peak_finder_core.sv
// ----------------------------------------------------------------------------
// spectrum_magnitude_peak_finder_core
// Each input word carries one complex FFT bin, real part in bits 15:0 and
// imaginary part in bits 31:16, both signed. The block returns one word per
// bin: the bin magnitude (dc bin as isqrt(re^2+im^2), all other bins as
// floor(2*sqrt(re^2+im^2))), the bin index, and the first bin of the frame
// holding the strictly largest magnitude so far. A word marked last closes
// the frame; the bin index also wraps after BINS bins and starts a new peak
// search there. After acceptance, a bin goes through two passes of a single
// 16x16 multiplier for the squares, 17 steps of a two-bits-per-step root
// unit, and a load state that fills the result register. The next word can
// be taken in the cycle after the load, so a new bin is only taken once the
// previous one is done; the 17-step root recurrence takes most of that time.
// The input side is not ready while a bin is being worked on; a finished
// result may wait in the output register while the next bin is accepted,
// and the load cycle stretches while that register is still full.
// ----------------------------------------------------------------------------
module spectrum_magnitude_peak_finder_core #(
    parameter int BINS = smpf_pkg::BINS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smpf_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output smpf_pkg::out_word_t m_data
);

    localparam int CNT_W  = $clog2(BINS);
    localparam int STEP_W = $clog2(smpf_pkg::ROOT_STEPS);
    localparam int TRY_W  = smpf_pkg::REM_W + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ_RE = 3'd1;
    localparam logic [2:0] ST_SQ_IM = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic signed [smpf_pkg::HALF_W-1:0]   re_reg, im_reg;
    logic                                 last_reg;
    logic [smpf_pkg::SUM_W-1:0]           acc_reg;
    logic [smpf_pkg::RAD_W-1:0]           rad_reg;
    logic [smpf_pkg::REM_W-1:0]           rem_reg;
    logic [smpf_pkg::MAG_W-1:0]           root_reg;
    logic [STEP_W-1:0]                    step_reg;

    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic [CNT_W-1:0]                     best_idx_reg, best_idx_next;
    logic [smpf_pkg::MAG_W-1:0]           best_mag_reg, best_mag_next;

    logic                                 m_valid_reg;
    smpf_pkg::out_word_t                  m_data_reg;

    // shared multiplier
    logic signed [smpf_pkg::HALF_W-1:0]   mul_op;
    logic signed [2*smpf_pkg::HALF_W-1:0] mul_prod;
    logic [smpf_pkg::SUM_W-1:0]           sum_full;
    logic [smpf_pkg::RAD_W-1:0]           radicand;
    logic                                 is_dc;

    // root step
    logic [TRY_W-1:0]                     trial;
    logic [TRY_W-1:0]                     test_val;
    logic [TRY_W-1:0]                     diff;
    logic                                 take_bit;

    logic                                 out_free;
    logic                                 peak_take;
    logic                                 s_accept;

    assign s_accept = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign is_dc    = (cnt_reg == '0);

    assign mul_op   = (state_reg == ST_SQ_RE) ? re_reg : im_reg;
    assign mul_prod = mul_op * mul_op;
    assign sum_full = acc_reg + smpf_pkg::SUM_W'($unsigned(mul_prod));
    assign radicand = is_dc ? {2'b00, sum_full} : {sum_full, 2'b00};

    assign trial    = {rem_reg, rad_reg[smpf_pkg::RAD_W-1 -: 2]};
    assign test_val = TRY_W'({root_reg, 2'b01});
    assign diff     = trial - test_val;
    assign take_bit = (trial >= test_val);

    assign peak_take     = is_dc || (root_reg > best_mag_reg);
    assign best_idx_next = peak_take ? cnt_reg : best_idx_reg;
    assign best_mag_next = peak_take ? root_reg : best_mag_reg;
    assign cnt_next      = (last_reg || cnt_reg == CNT_W'(BINS - 1)) ? '0 : cnt_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SQ_RE;
                end
            end
            ST_SQ_RE: state_next = ST_SQ_IM;
            ST_SQ_IM: state_next = ST_ROOT;
            ST_ROOT: begin
                if (step_reg == STEP_W'(smpf_pkg::ROOT_STEPS - 1)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            best_idx_reg <= '0;
            best_mag_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD && out_free) begin
                cnt_reg      <= cnt_next;
                best_idx_reg <= best_idx_next;
                best_mag_reg <= best_mag_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            re_reg   <= $signed(s_data.fft_bin[smpf_pkg::HALF_W-1:0]);
            im_reg   <= $signed(s_data.fft_bin[smpf_pkg::BIN_W-1:smpf_pkg::HALF_W]);
            last_reg <= s_data.last_bin;
        end
        unique case (state_reg)
            ST_SQ_RE: begin
                acc_reg <= smpf_pkg::SUM_W'($unsigned(mul_prod));
            end
            ST_SQ_IM: begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
            end
            ST_ROOT: begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= take_bit ? diff[smpf_pkg::REM_W-1:0]
                                     : trial[smpf_pkg::REM_W-1:0];
                root_reg <= {root_reg[smpf_pkg::MAG_W-2:0], take_bit};
                step_reg <= step_reg + 1'b1;
            end
            ST_LOAD: begin
                if (out_free) begin
                    m_data_reg.magnitude      <= root_reg;
                    m_data_reg.bin_index      <= smpf_pkg::IDX_W'(cnt_reg);
                    m_data_reg.peak_index     <= smpf_pkg::IDX_W'(best_idx_next);
                    m_data_reg.peak_magnitude <= best_mag_next;
                    m_data_reg.frame_done     <= last_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/smpf_checker.sv
// ----------------------------------------------------------------------------
// smpf_checker
// Port-level checks for the spectrum magnitude and peak finder, bound to
// the core module.
// ----------------------------------------------------------------------------
module smpf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input smpf_pkg::in_word_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input smpf_pkg::out_word_t m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // running peak never below the current bin
    a_peak_ge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.peak_magnitude >= m_data.magnitude)
        else $error("peak magnitude below bin magnitude");

    // busy once a word is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a bin is in work");

    // no result straight out of reset
    a_reset_clear: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

endmodule

bind spectrum_magnitude_peak_finder_core smpf_checker u_smpf_checker (.*);
